// File: rtl/vpd_pkg.sv
// Package for the VP9 payload descriptor parser: phase codes, constants, result record.
package vpd_pkg;

    // Descriptor flag bits of the first byte
    localparam logic [7:0] BIT_I = 8'b1000_0000;
    localparam logic [7:0] BIT_P = 8'b0100_0000;
    localparam logic [7:0] BIT_L = 8'b0010_0000;
    localparam logic [7:0] BIT_F = 8'b0001_0000;
    localparam logic [7:0] BIT_B = 8'b0000_1000;
    localparam logic [7:0] BIT_V = 8'b0000_0010;
    // M bit of picture ID, N bit of reference byte
    localparam logic [7:0] BIT_M = 8'b1000_0000;
    localparam logic [7:0] BIT_N = 8'b0000_0001;

    localparam int unsigned LEN_W = 11;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Flexible-mode reference chain limit
    localparam logic [1:0] MAX_REF_PICS = 2'd3;

    // Result queue between parser and output side
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [3:0] {
        PH_FIRST = 4'd0,
        PH_PID1  = 4'd1,
        PH_PID2  = 4'd2,
        PH_LAYER = 4'd3,
        PH_TL0   = 4'd4,
        PH_REFS  = 4'd5,
        PH_SS    = 4'd6,
        PH_RES   = 4'd7,
        PH_NG    = 4'd8,
        PH_PGB   = 4'd9,
        PH_PGREF = 4'd10,
        PH_DONE  = 4'd11
    } phase_t;

    typedef struct packed {
        logic [7:0]       byte_out;
        logic             is_payload;
        logic             packet_end;
        logic             truncated;
        logic             frame_start;
        logic [LEN_W-1:0] descriptor_length;
    } result_t;

endpackage

// File: rtl/vp9_payload_descriptor_parser.sv
// Top level of the VP9 RTP payload descriptor parser.
//
// Input side: one payload byte per transfer (payload_byte, last_byte), taken
// on a clock edge with push high and full low. Bytes of one packet come in
// order, descriptor first; last_byte marks the final one.
// Output side: one result per input byte, oldest first. While empty is low
// the result fields are valid; a transfer completes with pop high.
// Each result carries the byte, whether it is frame data (is_payload), the
// packet end mark, the frame_start (B) bit and the descriptor length so far.
// On the last byte, truncated = 1 says the descriptor was cut: drop packet.
// Latency: a result can be popped the cycle after its byte is pushed.
// Throughput: one byte per cycle while full is low, set by the phase update in
// the parser. A four-entry result queue decouples the two sides: when pop
// stays low the queue fills and full rises after four held results.
// Reset (rst_n low, asynchronous) empties the queue and puts the parser at
// the first descriptor byte of a new packet.
module vp9_payload_descriptor_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    payload_byte,
    input  logic                          last_byte,
    input  logic                          pop,
    output logic                          empty,
    output logic [7:0]                    byte_out,
    output logic                          is_payload,
    output logic                          packet_end,
    output logic                          truncated,
    output logic                          frame_start,
    output logic [vpd_pkg::LEN_W-1:0]     descriptor_length
);

    logic             accept;
    vpd_pkg::result_t front_res;
    vpd_pkg::result_t head_res;

    // byte is taken only when the queue has room for its result
    assign accept = push && !full;

    vpd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .result       (front_res)
    );

    vpd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_res),
        .full    (full),
        .rd_en   (pop),
        .empty   (empty),
        .rd_data (head_res)
    );

    assign byte_out          = head_res.byte_out;
    assign is_payload        = head_res.is_payload;
    assign packet_end        = head_res.packet_end;
    assign truncated         = head_res.truncated;
    assign frame_start       = head_res.frame_start;
    assign descriptor_length = head_res.descriptor_length;

    a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !truncated || packet_end)
        else $error("truncated flagged away from packet end");

    a_payload_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && is_payload && packet_end |-> !truncated)
        else $error("payload byte reported with truncated descriptor");

    a_first_len: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !is_payload |-> descriptor_length != '0)
        else $error("descriptor byte with zero length");

endmodule

// File: rtl/vpd_front.sv
// Descriptor walker: classifies each accepted byte and builds its result record.
module vpd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        payload_byte,
    input  logic              last_byte,
    output vpd_pkg::result_t  result
);

    vpd_pkg::phase_t             phase_reg, phase_next;
    logic [7:0]                  flags_reg, flags_next;
    logic [5:0]                  bytes_left_reg, bytes_left_next;
    logic [7:0]                  groups_left_reg, groups_left_next;
    logic [1:0]                  refs_reg, refs_next;
    logic                        gp_reg, gp_next;
    logic [vpd_pkg::LEN_W-1:0]   len_reg, len_next;

    logic                        payload;
    logic                        trunc;
    logic [1:0]                  refs_inc;
    logic [5:0]                  bl_dec;
    logic [7:0]                  grp_dec;
    logic [3:0]                  res_cnt;

    function automatic vpd_pkg::phase_t after_refs(input logic [7:0] f);
        after_refs = ((f & vpd_pkg::BIT_V) != 8'd0) ? vpd_pkg::PH_SS : vpd_pkg::PH_DONE;
    endfunction

    function automatic vpd_pkg::phase_t after_layer(input logic [7:0] f);
        if (((f & vpd_pkg::BIT_P) != 8'd0) && ((f & vpd_pkg::BIT_F) != 8'd0))
        begin
            after_layer = vpd_pkg::PH_REFS;
        end
        else
        begin
            after_layer = after_refs(f);
        end
    endfunction

    function automatic vpd_pkg::phase_t after_pid(input logic [7:0] f);
        after_pid = ((f & vpd_pkg::BIT_L) != 8'd0) ? vpd_pkg::PH_LAYER : after_layer(f);
    endfunction

    function automatic vpd_pkg::phase_t after_first(input logic [7:0] f);
        after_first = ((f & vpd_pkg::BIT_I) != 8'd0) ? vpd_pkg::PH_PID1 : after_pid(f);
    endfunction

    function automatic vpd_pkg::phase_t after_group(input logic [7:0] g);
        after_group = (g == 8'd0) ? vpd_pkg::PH_DONE : vpd_pkg::PH_PGB;
    endfunction

    always_comb
    begin
        payload          = (phase_reg != vpd_pkg::PH_FIRST) && (phase_reg >= vpd_pkg::PH_DONE);
        len_next         = (!payload && len_reg != vpd_pkg::LEN_MAX) ? len_reg + 1'b1 : len_reg;
        phase_next       = phase_reg;
        flags_next       = flags_reg;
        bytes_left_next  = bytes_left_reg;
        groups_left_next = groups_left_reg;
        refs_next        = refs_reg;
        gp_next          = gp_reg;
        refs_inc         = refs_reg + 2'd1;
        bl_dec           = bytes_left_reg - 6'd1;
        grp_dec          = groups_left_reg - 8'd1;
        res_cnt          = {1'b0, payload_byte[7:5]} + 4'd1;

        case (phase_reg)
            vpd_pkg::PH_FIRST:
            begin
                flags_next = payload_byte;
                refs_next  = 2'd0;
                phase_next = after_first(payload_byte);
            end
            vpd_pkg::PH_PID1:
            begin
                phase_next = ((payload_byte & vpd_pkg::BIT_M) != 8'd0) ? vpd_pkg::PH_PID2
                                                                       : after_pid(flags_reg);
            end
            vpd_pkg::PH_PID2:
            begin
                phase_next = after_pid(flags_reg);
            end
            vpd_pkg::PH_LAYER:
            begin
                phase_next = ((flags_reg & vpd_pkg::BIT_F) != 8'd0) ? after_layer(flags_reg)
                                                                    : vpd_pkg::PH_TL0;
            end
            vpd_pkg::PH_TL0:
            begin
                phase_next = after_layer(flags_reg);
            end
            vpd_pkg::PH_REFS:
            begin
                refs_next = refs_inc;
                if (((payload_byte & vpd_pkg::BIT_N) == 8'd0) || refs_inc >= vpd_pkg::MAX_REF_PICS)
                begin
                    phase_next = after_refs(flags_reg);
                end
            end
            vpd_pkg::PH_SS:
            begin
                gp_next = payload_byte[3];
                if (payload_byte[4])
                begin
                    // four resolution bytes per spatial layer
                    bytes_left_next = {res_cnt, 2'b00};
                    phase_next      = vpd_pkg::PH_RES;
                end
                else
                begin
                    phase_next = payload_byte[3] ? vpd_pkg::PH_NG : vpd_pkg::PH_DONE;
                end
            end
            vpd_pkg::PH_RES:
            begin
                bytes_left_next = bl_dec;
                if (bl_dec == 6'd0)
                begin
                    phase_next = gp_reg ? vpd_pkg::PH_NG : vpd_pkg::PH_DONE;
                end
            end
            vpd_pkg::PH_NG:
            begin
                groups_left_next = payload_byte;
                phase_next       = after_group(payload_byte);
            end
            vpd_pkg::PH_PGB:
            begin
                groups_left_next = grp_dec;
                bytes_left_next  = {4'd0, payload_byte[3:2]};
                phase_next       = (payload_byte[3:2] != 2'd0) ? vpd_pkg::PH_PGREF
                                                               : after_group(grp_dec);
            end
            vpd_pkg::PH_PGREF:
            begin
                bytes_left_next = bl_dec;
                if (bl_dec == 6'd0)
                begin
                    phase_next = after_group(groups_left_reg);
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // cut inside reference bytes is fine unless the SS still had to come
        if (!last_byte)
        begin
            trunc = 1'b0;
        end
        else if (phase_next == vpd_pkg::PH_REFS)
        begin
            trunc = (flags_next & vpd_pkg::BIT_V) != 8'd0;
        end
        else
        begin
            trunc = phase_next < vpd_pkg::PH_DONE;
        end

        result.byte_out          = payload_byte;
        result.is_payload        = payload;
        result.packet_end        = last_byte;
        result.truncated         = trunc;
        result.frame_start       = (flags_next & vpd_pkg::BIT_B) != 8'd0;
        result.descriptor_length = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= vpd_pkg::PH_FIRST;
            flags_reg       <= 8'd0;
            bytes_left_reg  <= 6'd0;
            groups_left_reg <= 8'd0;
            refs_reg        <= 2'd0;
            gp_reg          <= 1'b0;
            len_reg         <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg       <= vpd_pkg::PH_FIRST;
                flags_reg       <= 8'd0;
                bytes_left_reg  <= 6'd0;
                groups_left_reg <= 8'd0;
                refs_reg        <= 2'd0;
                gp_reg          <= 1'b0;
                len_reg         <= '0;
            end
            else
            begin
                phase_reg       <= phase_next;
                flags_reg       <= flags_next;
                bytes_left_reg  <= bytes_left_next;
                groups_left_reg <= groups_left_next;
                refs_reg        <= refs_next;
                gp_reg          <= gp_next;
                len_reg         <= len_next;
            end
        end
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> phase_reg == vpd_pkg::PH_FIRST && len_reg == '0)
        else $error("parser did not restart after packet end");

    a_len_mono: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_byte |=> len_reg >= $past(len_reg))
        else $error("descriptor length went backwards inside a packet");

    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        accept && payload |-> len_next == len_reg)
        else $error("payload byte counted as descriptor");

endmodule

// File: rtl/vpd_queue.sv
// Short result queue between the parser and the output side.
module vpd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  vpd_pkg::result_t  wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic              empty,
    output vpd_pkg::result_t  rd_data
);

    vpd_pkg::result_t         mem [vpd_pkg::Q_DEPTH];
    logic [vpd_pkg::Q_AW-1:0] wr_ptr_reg;
    logic [vpd_pkg::Q_AW-1:0] rd_ptr_reg;
    logic [vpd_pkg::Q_AW:0]   count_reg;
    logic                     do_wr;
    logic                     do_rd;

    assign full    = count_reg == (vpd_pkg::Q_AW+1)'(vpd_pkg::Q_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (vpd_pkg::Q_AW+1)'(vpd_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[vpd_pkg::Q_AW-1:0])
        else $error("queue pointers disagree with count");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !rd_en |=> $stable(rd_data))
        else $error("head entry changed while not read");

endmodule
